/* hw/rtl/h264fu_pkg.sv */
// Package for the H.264 RTP FU-A packetizer: widths, protocol constants,
// config register indexes and the front-to-back queue entry type. No dependencies.
package h264fu_pkg;

    // Field widths
    localparam int LEN_BITS      = 24;
    localparam int SUM_W         = LEN_BITS + 1;
    localparam int PLEN_W        = 16;
    localparam int SEQ_W         = 16;
    localparam int TIME_W        = 32;

    // RTP / FU-A constants
    localparam int RTP_HDR_BYTES = 12;
    localparam logic [PLEN_W-1:0] MAX_CAP = 16'd65521;
    localparam logic [4:0]  FU_A_TYPE  = 5'd28;

    // Config port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 1'd1;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1400;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One queued packet step: a payload byte, optionally preceded by FU bytes
    typedef struct packed {
        logic [7:0]        data;
        logic [7:0]        fu_ind;
        logic [7:0]        fu_hdr;
        logic              has_fu;
        logic              pkt_start;
        logic              pkt_end;
        logic              marker;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] rtp_time;
        logic [PLEN_W-1:0] plen;
    } t_entry;

endpackage

/* hw/rtl/h264fu_in_if.sv */
// Input channel of the packetizer: NAL unit bytes with unit length and timestamp.
// Depends on h264fu_pkg.
interface h264fu_in_if import h264fu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [7:0]          data_byte;
    logic                start_of_unit;
    logic [LEN_BITS-1:0] unit_length;
    logic [TIME_W-1:0]   capture_time;

    modport source (output valid, data_byte, start_of_unit, unit_length, capture_time,
                    input ready);
    modport sink   (input valid, data_byte, start_of_unit, unit_length, capture_time,
                    output ready);
endinterface

/* hw/rtl/h264fu_out_if.sv */
// Output channel of the packetizer: RTP payload bytes with packet side info.
// Depends on h264fu_pkg.
interface h264fu_out_if import h264fu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [7:0]        out_byte;
    logic              packet_start;
    logic              packet_end;
    logic              marker_bit;
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] rtp_time;
    logic [PLEN_W-1:0] payload_length;
    logic [PLEN_W-1:0] interleave_length;
    logic [7:0]        channel_id;

    modport source (output valid, out_byte, packet_start, packet_end, marker_bit,
                    seq_number, rtp_time, payload_length, interleave_length, channel_id,
                    input ready);
    modport sink   (input valid, out_byte, packet_start, packet_end, marker_bit,
                    seq_number, rtp_time, payload_length, interleave_length, channel_id,
                    output ready);
endinterface

/* hw/rtl/h264fu_front.sv */
// Front part: accepts NAL bytes, tracks unit/fragment state, builds queue entries.
// Depends on h264fu_pkg and h264fu_in_if.
module h264fu_front
    import h264fu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_max_payload,
    input  logic               i_queue_ready,
    h264fu_in_if.sink          i_in,
    output logic               o_push,
    output t_entry             o_entry
);

    logic [SEQ_W-1:0]    r_seq,  n_seq;
    logic [7:0]          r_nal,  n_nal;
    logic [LEN_BITS-1:0] r_left, n_left;
    logic [15:0]         r_fill, n_fill;
    logic                r_frag, n_frag;
    logic                r_first, n_first;
    logic [TIME_W-1:0]   r_time, n_time;

    logic                w_acc;
    logic [15:0]         w_max;
    logic [LEN_BITS-1:0] w_len;
    logic                w_fits;
    logic                w_lone;
    logic [SUM_W-1:0]    w_sum;
    logic [16:0]         w_fill1;
    logic                w_left_one;
    logic                w_last;
    logic                w_unit_ends;
    logic [16:0]         w_pay;

    assign i_in.ready = i_queue_ready;
    assign w_acc      = i_in.valid & i_queue_ready;

    // Clamp the payload limit to a usable range
    always_comb begin
        if (i_max_payload == 16'd0) begin
            w_max = 16'd1;
        end else if (i_max_payload > MAX_CAP) begin
            w_max = MAX_CAP;
        end else begin
            w_max = i_max_payload;
        end
    end

    // Start-of-unit classification
    assign w_len  = (i_in.unit_length == '0) ? LEN_BITS'(1) : i_in.unit_length;
    assign w_fits = w_len <= LEN_BITS'(w_max);
    assign w_lone = w_len == LEN_BITS'(1);

    // Fragment boundary decisions
    assign w_sum       = SUM_W'(r_fill) + SUM_W'(r_left);
    assign w_fill1     = 17'(r_fill) + 17'd1;
    assign w_left_one  = r_left == LEN_BITS'(1);
    assign w_last      = w_left_one || (w_fill1 >= 17'(w_max));
    assign w_unit_ends = w_left_one || (w_sum <= SUM_W'(w_max));

    always_comb begin
        if (w_last) begin
            w_pay = w_fill1;
        end else if (w_sum < SUM_W'(w_max)) begin
            w_pay = 17'(w_sum);
        end else begin
            w_pay = 17'(w_max);
        end
    end

    // Next state and queue entry
    always_comb begin
        n_seq   = r_seq;
        n_nal   = r_nal;
        n_left  = r_left;
        n_fill  = r_fill;
        n_frag  = r_frag;
        n_first = r_first;
        n_time  = r_time;
        o_push  = 1'b0;

        o_entry.data      = i_in.data_byte;
        o_entry.fu_ind    = {r_nal[7:5], FU_A_TYPE};
        o_entry.fu_hdr    = {r_first, w_unit_ends, 1'b0, r_nal[4:0]};
        o_entry.has_fu    = 1'b0;
        o_entry.pkt_start = 1'b0;
        o_entry.pkt_end   = 1'b0;
        o_entry.marker    = 1'b1;
        o_entry.seq       = r_seq;
        o_entry.rtp_time  = r_time;
        o_entry.plen      = w_sum[15:0];

        if (w_acc) begin
            if (i_in.start_of_unit) begin
                n_time  = i_in.capture_time;
                n_nal   = i_in.data_byte;
                n_first = 1'b1;
                n_left  = w_len - LEN_BITS'(1);
                if (w_fits) begin
                    // Single NAL unit packet
                    n_frag            = 1'b0;
                    o_push            = 1'b1;
                    o_entry.pkt_start = 1'b1;
                    o_entry.pkt_end   = w_lone;
                    o_entry.rtp_time  = i_in.capture_time;
                    o_entry.plen      = w_len[15:0];
                    if (w_lone) begin
                        n_fill = 16'd0;
                        n_seq  = r_seq + SEQ_W'(1);
                    end else begin
                        n_fill = 16'd1;
                    end
                end else begin
                    // Header byte is folded into the FU bytes
                    n_frag = 1'b1;
                    n_fill = 16'd0;
                end
            end else if (r_left != '0) begin
                o_push = 1'b1;
                n_left = r_left - LEN_BITS'(1);
                if (!r_frag) begin
                    o_entry.pkt_end = w_left_one;
                    if (w_left_one) begin
                        n_fill = 16'd0;
                        n_seq  = r_seq + SEQ_W'(1);
                    end else begin
                        n_fill = r_fill + 16'd1;
                    end
                end else begin
                    o_entry.has_fu  = (r_fill == 16'd0);
                    o_entry.pkt_end = w_last;
                    o_entry.marker  = w_unit_ends;
                    o_entry.plen    = w_pay[15:0] + 16'd2;
                    if (r_fill == 16'd0) begin
                        n_first = 1'b0;
                    end
                    if (w_last) begin
                        n_fill = 16'd0;
                        n_seq  = r_seq + SEQ_W'(1);
                    end else begin
                        n_fill = r_fill + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_nal   <= '0;
            r_left  <= '0;
            r_fill  <= '0;
            r_frag  <= 1'b0;
            r_first <= 1'b1;
            r_time  <= '0;
        end else begin
            r_seq   <= n_seq;
            r_nal   <= n_nal;
            r_left  <= n_left;
            r_fill  <= n_fill;
            r_frag  <= n_frag;
            r_first <= n_first;
            r_time  <= n_time;
        end
    end

endmodule

/* hw/rtl/h264fu_queue.sv */
// Short register queue of packet steps between front and back.
// Depends on h264fu_pkg.
module h264fu_queue
    import h264fu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_ready = r_count != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/h264fu_back.sv */
// Back part: expands queue entries into output beats (FU indicator, FU header, byte).
// Depends on h264fu_pkg and h264fu_out_if.
module h264fu_back
    import h264fu_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_channel,
    input  logic           i_q_valid,
    input  t_entry         i_q_entry,
    output logic           o_pop,
    h264fu_out_if.source   o_out
);

    typedef enum logic [1:0] {
        BT_IND,
        BT_HDR,
        BT_DATA
    } t_beat;

    t_beat  r_beat;
    logic   r_valid;
    t_entry r_cur;

    logic   w_fire;
    logic   w_done;
    logic   w_load;

    assign w_fire = r_valid & o_out.ready;
    assign w_done = w_fire & (r_beat == BT_DATA);
    assign w_load = i_q_valid & (!r_valid | w_done);
    assign o_pop  = w_load;

    // Beat sequencing and current entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BT_DATA;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_cur   <= i_q_entry;
            r_beat  <= i_q_entry.has_fu ? BT_IND : BT_DATA;
        end else if (w_done) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            case (r_beat)
                BT_IND:  r_beat <= BT_HDR;
                BT_HDR:  r_beat <= BT_DATA;
                default: r_beat <= BT_DATA;
            endcase
        end
    end

    // Beat payload
    always_comb begin
        case (r_beat)
            BT_IND: begin
                o_out.out_byte     = r_cur.fu_ind;
                o_out.packet_start = 1'b1;
                o_out.packet_end   = 1'b0;
            end
            BT_HDR: begin
                o_out.out_byte     = r_cur.fu_hdr;
                o_out.packet_start = 1'b0;
                o_out.packet_end   = 1'b0;
            end
            default: begin
                o_out.out_byte     = r_cur.data;
                o_out.packet_start = r_cur.pkt_start;
                o_out.packet_end   = r_cur.pkt_end;
            end
        endcase
    end

    assign o_out.valid             = r_valid;
    assign o_out.marker_bit        = r_cur.marker;
    assign o_out.seq_number        = r_cur.seq;
    assign o_out.rtp_time          = r_cur.rtp_time;
    assign o_out.payload_length    = r_cur.plen;
    assign o_out.interleave_length = r_cur.plen + PLEN_W'(RTP_HDR_BYTES);
    assign o_out.channel_id        = i_channel;

    a_ind_then_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_beat == BT_IND) |=> (r_valid && r_beat == BT_HDR))
        else $error("FU indicator not followed by FU header");

    a_fu_beats_need_fu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_beat != BT_DATA) |-> r_cur.has_fu)
        else $error("FU beat on an entry without FU bytes");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_beat) && !$past(o_pop)))
        else $error("back stage moved while output stalled");

endmodule

/* hw/rtl/h264_rtp_fu_a_packetizer.sv */
// Top level of the H.264 RTP packetizer (single NAL unit and FU-A packets).
// Depends on h264fu_pkg, h264fu_in_if, h264fu_out_if, h264fu_front, h264fu_queue,
// h264fu_back.
//
// Usage:
//   i_in carries one NAL unit byte per beat; start_of_unit marks the NAL header byte,
//   which also brings unit_length and capture_time. o_out carries one RTP payload
//   byte per beat with packet_start/packet_end, marker, sequence number, timestamp,
//   payload and TCP interleave lengths and the interleave channel.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0: max_payload,
//   1: interleave_channel); write only while the block is idle.
// Timing:
//   The front takes one input beat per cycle whenever the 4-entry queue has room.
//   A result beat is registered in the queue and then in the back stage. Each input
//   byte gives one output beat, and the first byte of an FU-A fragment gives three
//   (FU indicator, FU header, byte), so the output side runs at one beat per cycle
//   while the receiver is ready, and the input stalls on each fragment once the
//   queue fills. The header byte of a fragmented unit produces no beat.
// Reset (synchronous, active low) empties the queue, restarts sequence numbers at
//   zero and sets max_payload to 1400 and the channel to 0. A stalled receiver
//   holds the current beat; the queue fills and then input ready drops.
module h264_rtp_fu_a_packetizer
    import h264fu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    h264fu_in_if.sink             i_in,
    h264fu_out_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_max_payload;
    logic [7:0]  r_channel;

    logic        w_push;
    t_entry      w_push_entry;
    logic        w_q_ready;
    logic        w_q_valid;
    t_entry      w_q_entry;
    logic        w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_channel     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[15:0];
                CFG_CHANNEL:     r_channel     <= i_cfg_data[7:0];
                default:         r_channel     <= r_channel;
            endcase
        end
    end

    h264fu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_payload (r_max_payload),
        .i_queue_ready (w_q_ready),
        .i_in          (i_in),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    h264fu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    h264fu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_channel (r_channel),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

/* verif/h264_rtp_fu_a_packetizer_tb.sv */
// Self-checking testbench for the H.264 RTP FU-A packetizer: a bit-exact packetizing
// model predicts every payload beat, traffic mixes directed units, random units and stalls.
// Depends on h264fu_pkg, h264fu_in_if, h264fu_out_if and h264_rtp_fu_a_packetizer.
module h264_rtp_fu_a_packetizer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import h264fu_pkg::*;

    localparam int IDLE_LIMIT   = 5000;  // cycles with no beat before giving up
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE       = 12;    // cycles to let a beat with no output finish
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic [7:0]        pay_byte;
        logic              pkt_start;
        logic              pkt_end;
        logic              marker;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
        logic [PLEN_W-1:0] plen;
        logic [PLEN_W-1:0] ilen;
        logic [7:0]        chan;
    } t_rtp_beat;

    typedef enum {RX_OPEN, RX_COIN, RX_BURSTY} t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    h264fu_in_if  nal_in();
    h264fu_out_if rtp_out();

    h264_rtp_fu_a_packetizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (nal_in),
        .o_out      (rtp_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Packetizer model state and its copy of the registers
    logic [15:0]         lim_reg;
    logic [7:0]          chan_reg;
    logic [SEQ_W-1:0]    seq_cnt;
    logic [7:0]          nal_hdr;
    logic [LEN_BITS-1:0] bytes_left;
    logic [PLEN_W-1:0]   frag_fill;
    bit                  in_fu_mode;
    bit                  first_frag;
    logic [TIME_W-1:0]   unit_ts;

    t_rtp_beat expected_beats[$];
    int  err_cnt    = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    bit  steady_send = 0;
    int  hold_reqs  = 0;
    int  idle_cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_limit();
        int unsigned m;
        m = lim_reg;
        if (m < 1) m = 1;
        if (m > MAX_CAP) m = MAX_CAP;
        return m;
    endfunction

    function automatic void emit_beat(input logic [7:0] b, input bit ps, input bit pe,
                                      input bit mk, input int unsigned plen);
        t_rtp_beat e;
        e.pay_byte  = b;
        e.pkt_start = ps;
        e.pkt_end   = pe;
        e.marker    = mk;
        e.seq       = seq_cnt;
        e.ts        = unit_ts;
        e.plen      = plen[15:0];
        e.ilen      = 16'(plen + RTP_HDR_BYTES);
        e.chan      = chan_reg;
        expected_beats.push_back(e);
    endfunction

    // Predict the payload beats that one accepted NAL byte produces
    function automatic void packetize_byte(input logic [7:0] d, input logic sou,
                                           input logic [LEN_BITS-1:0] len_in,
                                           input logic [TIME_W-1:0] ts_in);
        int unsigned m, len, fill, rest, pay;
        bit last, unit_ends;
        logic [7:0] hdr;
        m = eff_limit();
        if (sou) begin
            len = len_in;
            if (len == 0) len = 1;
            unit_ts    = ts_in;
            nal_hdr    = d;
            first_frag = 1'b1;
            bytes_left = LEN_BITS'(len - 1);
            if (len <= m) begin
                in_fu_mode = 1'b0;
                frag_fill  = 1;
                emit_beat(d, 1'b1, bytes_left == 0, 1'b1, len);
                if (bytes_left == 0) begin
                    frag_fill = 0;
                    seq_cnt++;
                end
            end else begin
                in_fu_mode = 1'b1;
                frag_fill  = 0;
            end
            return;
        end
        if (bytes_left == 0) return;
        // single NAL unit packet body
        if (!in_fu_mode) begin
            last = (bytes_left == 1);
            emit_beat(d, 1'b0, last, 1'b1, frag_fill + bytes_left);
            frag_fill++;
            bytes_left--;
            if (last) begin
                frag_fill = 0;
                seq_cnt++;
            end
            return;
        end
        // FU-A fragment body
        fill      = frag_fill;
        rest      = bytes_left;
        last      = (rest == 1) || (fill + 1 >= m);
        unit_ends = (rest == 1) || (fill + rest <= m);
        if (last) pay = fill + 1;
        else pay = (fill + rest < m) ? fill + rest : m;
        if (fill == 0) begin
            hdr = {3'b000, nal_hdr[4:0]};
            if (first_frag) hdr |= 8'h80;
            if (unit_ends) hdr |= 8'h40;
            emit_beat({nal_hdr[7:5], FU_A_TYPE}, 1'b1, 1'b0, unit_ends, pay + 2);
            emit_beat(hdr, 1'b0, 1'b0, unit_ends, pay + 2);
            first_frag = 1'b0;
        end
        emit_beat(d, 1'b0, last, unit_ends, pay + 2);
        frag_fill++;
        bytes_left--;
        if (last) begin
            frag_fill = 0;
            seq_cnt++;
        end
    endfunction

    task automatic flag_error(input string msg);
        if (err_cnt < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Offer one NAL byte; bursts with random gaps unless steady_send is set
    task automatic push_byte(input logic [7:0] d, input logic sou,
                             input logic [LEN_BITS-1:0] len, input logic [TIME_W-1:0] ts);
        int gap;
        if (!steady_send && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                nal_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        nal_in.valid         <= 1'b1;
        nal_in.data_byte     <= d;
        nal_in.start_of_unit <= sou;
        nal_in.unit_length   <= len;
        nal_in.capture_time  <= ts;
        do @(posedge i_clk); while (!nal_in.ready);
        packetize_byte(d, sou, len, ts);
        items_sent++;
    endtask

    // Header with the given length field, then nbytes body bytes with junk side fields
    task automatic send_unit(input logic [LEN_BITS-1:0] len_field, input int unsigned nbytes);
        push_byte(8'($urandom), 1'b1, len_field, $urandom);
        repeat (nbytes) push_byte(8'($urandom), 1'b0, LEN_BITS'($urandom), $urandom);
    endtask

    // Stop offering, wait for every expected beat, then let the pipe settle
    task automatic wait_drained();
        nal_in.valid <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_MAX_PAYLOAD) lim_reg = val;
        else if (idx == CFG_CHANNEL) chan_reg = val[7:0];
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random unit shaped around the current limit; mostly complete, some broken
    task automatic send_random_unit();
        int unsigned m, cap, len, r;
        m   = eff_limit();
        cap = (3 * m + 3 < 160) ? 3 * m + 3 : 160;
        r   = $urandom_range(0, 19);
        if (r < 15) begin
            case ($urandom_range(0, 5))
                0:       len = (m < cap) ? m : cap;
                1:       len = (m + 1 < cap) ? m + 1 : cap;
                2:       len = $urandom_range(1, (m < cap) ? m : cap);
                default: len = $urandom_range(1, cap);
            endcase
            send_unit(LEN_BITS'(len), len - 1);
        end else if (r < 17) begin
            // cut short by the next header
            send_unit(($urandom_range(0, 1) != 0) ? LEN_BITS'($urandom)
                                                  : LEN_BITS'($urandom_range(2, cap)),
                      $urandom_range(0, 20));
        end else if (r < 18) begin
            send_unit('0, 0);
        end else begin
            // stray bytes, ignored unless a unit is still open
            repeat ($urandom_range(1, 3))
                push_byte(8'($urandom), 1'b0, LEN_BITS'($urandom), $urandom);
        end
    endtask

    task automatic test_reset_values();
        send_unit(LEN_BITS'(4), 3);
        wait_drained();
    endtask

    task automatic test_fragment_edges();
        // limit 0 acts as 1: one payload byte per fragment
        write_reg(CFG_MAX_PAYLOAD, 16'd0);
        write_reg(CFG_CHANNEL, 16'h00FF);
        push_byte(8'hFF, 1'b1, LEN_BITS'(3), 32'hFFFF_FFFF);
        push_byte(8'h00, 1'b0, '0, '0);
        push_byte(8'hFF, 1'b0, '0, '0);
        wait_drained();
        write_reg(CFG_MAX_PAYLOAD, 16'd4);
        // lone fragment carrying both start and end
        push_byte(8'h00, 1'b1, LEN_BITS'(5), 32'h0000_0000);
        for (int i = 0; i < 4; i++) push_byte(8'($urandom), 1'b0, '0, '0);
        // exactly the limit: single packet
        send_unit(LEN_BITS'(4), 3);
        // byte with no open unit
        push_byte(8'h5A, 1'b0, LEN_BITS'($urandom), $urandom);
        // zero length counts as one
        send_unit('0, 0);
        // fragmented unit dropped by a new header
        send_unit(24'hFF_FFFF, 2);
        send_unit(LEN_BITS'(2), 1);
        // single packet dropped by a new header
        send_unit(LEN_BITS'(3), 1);
        send_unit(LEN_BITS'(1), 0);
        wait_drained();
    endtask

    task automatic test_limit_change();
        write_reg(CFG_MAX_PAYLOAD, 16'd8);
        send_unit(LEN_BITS'(12), 5);
        // sender pauses mid unit until everything has come out
        wait_drained();
        write_reg(CFG_MAX_PAYLOAD, 16'd3);
        write_reg(CFG_CHANNEL, 16'h0000);
        repeat (6) push_byte(8'($urandom), 1'b0, '0, '0);
        wait_drained();
    endtask

    task automatic test_limit_clamp();
        write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
        send_unit(LEN_BITS'(65522), 3);
        send_unit(LEN_BITS'(1), 0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [15:0] limits[8] = '{16'd16, 16'd17, 16'hFFFF, 16'd24, 16'd1, 16'd40, 16'd0, 16'd16};
        int target;
        for (int p = 0; p < 8; p++) begin
            if (p == 5) limits[p] = 16'($urandom_range(16, 64));
            if (p == 2 && $urandom_range(0, 1) != 0) limits[p] = 16'($urandom_range(100, 65000));
            write_reg(CFG_MAX_PAYLOAD, limits[p]);
            write_reg(CFG_CHANNEL, (p == 0) ? 16'hFF : 16'($urandom_range(0, 255)));
            target = items_sent + 20;
            while (items_sent < target) send_random_unit();
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        int target;
        write_reg(CFG_MAX_PAYLOAD, 16'd16);
        hold_reqs++;
        steady_send = 1'b1;
        target = items_sent + 40;
        while (items_sent < target) send_random_unit();
        steady_send = 1'b0;
        wait_drained();
    endtask

    // Run of one-byte header units (length field 0 or 1), each advancing the sequence number
    task automatic test_seq_advance();
        write_reg(CFG_CHANNEL, 16'($urandom_range(0, 255)));
        repeat (20) push_byte(8'($urandom), 1'b1, LEN_BITS'($urandom_range(0, 1)), $urandom);
        wait_drained();
    endtask

    // Receiver: stall pattern that changes mode, plus requested long hold-offs
    initial begin : rx_stall
        t_rx_mode mode;
        int mode_left, stall_left, hold_left, holds_done;
        mode = RX_OPEN;
        mode_left = 0;
        stall_left = 0;
        hold_left = 0;
        holds_done = 0;
        rtp_out.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_reqs) begin
                holds_done = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rtp_out.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    RX_OPEN: rtp_out.ready <= 1'b1;
                    RX_COIN: rtp_out.ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            rtp_out.ready <= 1'b0;
                        end else if ($urandom_range(0, 9) == 0) begin
                            stall_left = $urandom_range(1, 8);
                            rtp_out.ready <= 1'b0;
                        end else begin
                            rtp_out.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Output check: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        t_rtp_beat e;
        if (i_rst_n && rtp_out.valid && rtp_out.ready) begin
            if (expected_beats.size() == 0) begin
                flag_error($sformatf("unexpected output beat 0x%0h", rtp_out.out_byte));
            end else begin
                e = expected_beats.pop_front();
                check_field("out_byte", rtp_out.out_byte, e.pay_byte);
                check_field("packet_start", rtp_out.packet_start, e.pkt_start);
                check_field("packet_end", rtp_out.packet_end, e.pkt_end);
                check_field("marker_bit", rtp_out.marker_bit, e.marker);
                check_field("seq_number", rtp_out.seq_number, e.seq);
                check_field("rtp_time", rtp_out.rtp_time, e.ts);
                check_field("payload_length", rtp_out.payload_length, e.plen);
                check_field("interleave_length", rtp_out.interleave_length, e.ilen);
                check_field("channel_id", rtp_out.channel_id, e.chan);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (nal_in.valid && nal_in.ready) ||
            (rtp_out.valid && rtp_out.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles, %0d beats still expected",
                     IDLE_LIMIT, expected_beats.size());
            $display("h264_rtp_fu_a_packetizer: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_MAX_PAYLOAD;
        cfg_data             <= '0;
        nal_in.valid         <= 1'b0;
        nal_in.data_byte     <= '0;
        nal_in.start_of_unit <= 1'b0;
        nal_in.unit_length   <= '0;
        nal_in.capture_time  <= '0;
        lim_reg    = MAX_PAYLOAD_RST;
        chan_reg   = '0;
        seq_cnt    = '0;
        nal_hdr    = '0;
        bytes_left = '0;
        frag_fill  = '0;
        in_fu_mode = 1'b0;
        first_frag = 1'b1;
        unit_ts    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_fragment_edges();
        test_limit_change();
        test_limit_clamp();
        test_random_traffic();
        test_backpressure();
        test_seq_advance();

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && expected_beats.size() == 0) begin
            $display("h264_rtp_fu_a_packetizer: match");
        end else begin
            $display("h264_rtp_fu_a_packetizer: mismatch");
        end
        $finish;
    end

endmodule
